// ===== rtl/stok_pkg.sv =====
`timescale 1ns / 1ps
package stok_pkg;

   // Token field limits.
   localparam int MAX_LEXEME  = 99;
   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 24;
   localparam int LEN_BITS    = $clog2(MAX_LEXEME + 1);

   // Result queue geometry. One byte can produce up to PUSH_MAX tokens.
   localparam int PUSH_MAX    = 4;
   localparam int Q_DEPTH     = 8;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);
   localparam int PUSH_N_BITS = $clog2(PUSH_MAX + 1);

   // Token kinds.
   localparam logic [5:0] KIND_END        = 6'd0;
   localparam logic [5:0] KIND_IDENT      = 6'd1;
   localparam logic [5:0] KIND_NUMBER     = 6'd2;
   localparam logic [5:0] KIND_STRING     = 6'd3;
   localparam logic [5:0] KIND_KEYWORD0   = 6'd4;
   localparam logic [5:0] KIND_COLON_EQ   = 6'd20;
   localparam logic [5:0] KIND_EQ_EQ      = 6'd22;
   localparam logic [5:0] KIND_PLUS_EQ    = 6'd24;
   localparam logic [5:0] KIND_MINUS_EQ   = 6'd26;
   localparam logic [5:0] KIND_BANG_EQ    = 6'd28;
   localparam logic [5:0] KIND_LESS_EQ    = 6'd30;
   localparam logic [5:0] KIND_GREATER_EQ = 6'd32;
   localparam logic [5:0] KIND_AND_AND    = 6'd34;
   localparam logic [5:0] KIND_OR_OR      = 6'd35;
   localparam logic [5:0] KIND_SLASH      = 6'd36;
   localparam logic [5:0] KIND_PUNCT0     = 6'd37;
   localparam logic [5:0] KIND_DOT        = 6'd42;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_UNKNOWN = 2'd1;
   localparam logic [1:0] FAULT_LONE    = 2'd2;

   typedef struct packed {
      logic [5:0]             kind;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    length;
      logic [LINE_BITS-1:0]   line;
      logic [1:0]             fault;
   } result_type;

   typedef struct packed {
      logic       v;
      result_type r;
   } emit_type;

   typedef struct packed {
      result_type r;
      logic       run_end;
   } entry_type;

   typedef struct packed {
      logic [PUSH_N_BITS-1:0]   n;
      entry_type [PUSH_MAX-1:0] e;
   } push_type;

   typedef struct packed {
      logic                  stall;
      logic [Q_CNT_BITS-1:0] count;
   } q_status_type;

endpackage

// ===== rtl/stok_front.sv =====
`timescale 1ns / 1ps
module stok_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         source_byte,
   input  logic               first_byte,
   input  logic               last_byte,
   output stok_pkg::push_type push
);
   import stok_pkg::*;

   localparam logic [3:0] M_MARK    = 4'd0;
   localparam logic [3:0] M_IDLE    = 4'd1;
   localparam logic [3:0] M_IDENT   = 4'd2;
   localparam logic [3:0] M_NUM     = 4'd3;
   localparam logic [3:0] M_STR     = 4'd4;
   localparam logic [3:0] M_OP      = 4'd5;
   localparam logic [3:0] M_DOT     = 4'd6;
   localparam logic [3:0] M_SLASH   = 4'd7;
   localparam logic [3:0] M_COMMENT = 4'd8;

   localparam logic [63:0] KW_WORD [16] = '{
      64'h6669, 64'h65736c65, 64'h656c696877, 64'h726f66,
      64'h6f74, 64'h636e7566, 64'h6e7275746572, 64'h65757274,
      64'h65736c6166, 64'h6c6c756e, 64'h6b61657262, 64'h65756e69746e6f63,
      64'h657375, 64'h6d754e, 64'h727453, 64'h7961727241
   };
   localparam logic [3:0] KW_LEN [16] = '{
      4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd6, 4'd4,
      4'd5, 4'd4, 4'd5, 4'd8, 4'd3, 4'd3, 4'd3, 4'd5
   };
   localparam logic [7:0] PUNCT [11] = '{
      "(", ")", "{", "}", ",", ".", ";", "*", "%", "[", "]"
   };

   typedef struct packed {
      logic [3:0]             mode;
      logic [1:0]             stage;
      logic [7:0]             held;
      logic [63:0]            win;
      logic [OFFSET_BITS-1:0] tstart;
      logic [LEN_BITS-1:0]    tlen;
      logic [OFFSET_BITS-1:0] off;
      logic [LINE_BITS-1:0]   lc;
      logic [LINE_BITS-1:0]   tline;
      logic                   done;
   } st_type;

   typedef struct packed {
      st_type   s;
      emit_type e0;
      emit_type e1;
   } feed_type;

   st_type st_ff, st_in;

   function automatic st_type clear_state();
      st_type s;
      s = '0;
      s.mode  = M_MARK;
      s.lc    = LINE_BITS'(1);
      s.tline = LINE_BITS'(1);
      return s;
   endfunction

   function automatic logic [OFFSET_BITS-1:0] off_inc(logic [OFFSET_BITS-1:0] v);
      return (v == '1) ? v : v + OFFSET_BITS'(1);
   endfunction

   function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] v);
      return (v == '1) ? v : v + LINE_BITS'(1);
   endfunction

   function automatic emit_type mk(logic [5:0] kind, logic [OFFSET_BITS-1:0] start,
                                   logic [LEN_BITS-1:0] len, logic [LINE_BITS-1:0] line,
                                   logic [1:0] fault);
      emit_type e;
      e.v        = 1'b1;
      e.r.kind   = kind;
      e.r.start  = start;
      e.r.length = len;
      e.r.line   = line;
      e.r.fault  = fault;
      return e;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_op(logic [7:0] c);
      return c == ":" || c == "=" || c == "+" || c == "-" || c == "!" || c == "<" ||
             c == ">" || c == "&" || c == "|";
   endfunction

   function automatic logic [5:0] op_base(logic [7:0] c);
      logic [5:0] k;
      case (c)
         ":":     k = KIND_COLON_EQ;
         "=":     k = KIND_EQ_EQ;
         "+":     k = KIND_PLUS_EQ;
         "-":     k = KIND_MINUS_EQ;
         "!":     k = KIND_BANG_EQ;
         "<":     k = KIND_LESS_EQ;
         default: k = KIND_GREATER_EQ;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] ident_kind(logic [63:0] win, logic [LEN_BITS-1:0] len);
      logic [5:0] k;
      k = KIND_IDENT;
      for (int i = 15; i >= 0; i--) begin
         if (win == KW_WORD[i] && len == LEN_BITS'(KW_LEN[i])) k = KIND_KEYWORD0 + 6'(i);
      end
      return k;
   endfunction

   function automatic st_type add_char(st_type s, logic [7:0] c);
      st_type t;
      t = s;
      if (s.tlen < LEN_BITS'(8)) t.win[8 * s.tlen[2:0] +: 8] = c;
      if (s.tlen < LEN_BITS'(MAX_LEXEME)) t.tlen = s.tlen + LEN_BITS'(1);
      return t;
   endfunction

   function automatic emit_type flush_emit(st_type s);
      emit_type e;
      e = '0;
      case (s.mode)
         M_IDENT: e = mk(ident_kind(s.win, s.tlen), s.tstart, s.tlen, s.tline, FAULT_NONE);
         M_NUM:   e = mk(KIND_NUMBER, s.tstart, s.tlen, s.tline, FAULT_NONE);
         M_STR:   e = mk(KIND_STRING, s.tstart, s.tlen, s.tline, FAULT_NONE);
         M_OP: begin
            if (s.held == "&" || s.held == "|")
               e = mk(KIND_END, s.tstart, '0, s.tline, FAULT_LONE);
            else
               e = mk(op_base(s.held) + 6'd1, s.tstart, LEN_BITS'(1), s.tline, FAULT_NONE);
         end
         M_DOT:   e = mk(KIND_DOT, s.tstart, LEN_BITS'(1), s.tline, FAULT_NONE);
         M_SLASH: e = mk(KIND_SLASH, s.tstart, LEN_BITS'(1), s.tline, FAULT_NONE);
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic st_type begin_tok(st_type s, logic [3:0] mode, logic [7:0] c);
      st_type t;
      t = s;
      t.mode   = mode;
      t.tstart = s.off;
      t.tline  = s.lc;
      t.tlen   = LEN_BITS'(1);
      t.win    = 64'(c);
      return t;
   endfunction

   // Start a fresh lexeme from idle with this byte.
   function automatic feed_type fresh(st_type s, logic [7:0] c);
      feed_type f;
      logic     hit;
      f      = '0;
      f.s    = s;
      f.s.mode = M_IDLE;
      hit    = 1'b0;
      if (is_space(c)) begin
         hit = 1'b1;
      end else if (is_alpha(c)) begin
         f.s = begin_tok(s, M_IDENT, c);
      end else if (is_digit(c)) begin
         f.s = begin_tok(s, M_NUM, c);
      end else if (c == ".") begin
         f.s = begin_tok(s, M_DOT, c);
      end else if (c == "/") begin
         f.s = begin_tok(s, M_SLASH, c);
      end else if (c == "\"") begin
         f.s        = begin_tok(s, M_STR, c);
         f.s.tstart = off_inc(s.off);
         f.s.tlen   = '0;
         f.s.win    = '0;
      end else if (is_op(c)) begin
         f.s      = begin_tok(s, M_OP, c);
         f.s.held = c;
      end else begin
         for (int i = 0; i < 11; i++) begin
            if (PUNCT[i] == c) begin
               hit  = 1'b1;
               f.e1 = mk(KIND_PUNCT0 + 6'(i), s.off, LEN_BITS'(1), s.lc, FAULT_NONE);
            end
         end
         if (!hit) f.e1 = mk(KIND_END, s.off, '0, s.lc, FAULT_UNKNOWN);
      end
      return f;
   endfunction

   // One ordinary byte: at most a flushed token and then a one-byte token.
   function automatic feed_type feed(st_type s, logic [7:0] c);
      feed_type f;
      feed_type fz;
      logic     fl;
      logic     fr;
      f  = '0;
      f.s = s;
      fl = 1'b0;
      fr = 1'b0;
      case (s.mode)
         M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) f.s = add_char(s, c);
            else begin fl = 1'b1; fr = 1'b1; end
         end
         M_NUM: begin
            if (is_digit(c) || c == ".") f.s = add_char(s, c);
            else begin fl = 1'b1; fr = 1'b1; end
         end
         M_STR: begin
            if (c == "\"") fl = 1'b1;
            else f.s = add_char(s, c);
         end
         M_OP: begin
            if (s.held == "&" || s.held == "|") begin
               if (c == s.held) begin
                  f.e0 = mk((s.held == "&") ? KIND_AND_AND : KIND_OR_OR, s.tstart,
                            LEN_BITS'(2), s.tline, FAULT_NONE);
                  f.s.mode = M_IDLE;
               end else begin
                  fl = 1'b1;
                  fr = 1'b1;
               end
            end else if (c == "=") begin
               f.e0 = mk(op_base(s.held), s.tstart, LEN_BITS'(2), s.tline, FAULT_NONE);
               f.s.mode = M_IDLE;
            end else begin
               fl = 1'b1;
               fr = 1'b1;
            end
         end
         M_DOT: begin
            if (is_digit(c)) begin
               f.s      = add_char(s, c);
               f.s.mode = M_NUM;
            end else begin
               fl = 1'b1;
               fr = 1'b1;
            end
         end
         M_SLASH: begin
            if (c == "/") f.s.mode = M_COMMENT;
            else begin fl = 1'b1; fr = 1'b1; end
         end
         M_COMMENT: begin
            if (c == 8'h0A) f.s.mode = M_IDLE;
         end
         default: fr = 1'b1;
      endcase
      if (fl) begin
         f.e0     = flush_emit(f.s);
         f.s.mode = M_IDLE;
      end
      if (fr) begin
         fz   = fresh(f.s, c);
         f.s  = fz.s;
         f.e1 = fz.e1;
      end
      f.s.off = off_inc(f.s.off);
      if (c == 8'h0A) f.s.lc = line_inc(f.s.lc);
      return f;
   endfunction

   st_type     s0;
   st_type     s1;
   feed_type   fd;
   emit_type   cand [6];
   logic       mark_hit;
   logic [7:0] mark_byte;
   logic [PUSH_N_BITS-1:0] cnt;
   push_type   grp;

   always_comb begin
      s0 = first_byte ? clear_state() : st_ff;
      s1 = s0;
      fd = '0;
      mark_hit = 1'b0;
      for (int i = 0; i < 6; i++) cand[i] = '0;
      case (s0.stage)
         2'd0:    mark_byte = 8'hEF;
         2'd1:    mark_byte = 8'hBB;
         default: mark_byte = 8'hBF;
      endcase
      if (!s0.done) begin
         mark_hit = (s0.mode == M_MARK) && (source_byte != 8'd0) &&
                    (source_byte == mark_byte);
         if (mark_hit) begin
            if (s0.stage == 2'd2) begin
               s1.mode  = M_IDLE;
               s1.stage = 2'd0;
               s1.off   = off_inc(off_inc(off_inc(s0.off)));
            end else begin
               s1.stage = s0.stage + 2'd1;
            end
         end
         // A broken mark: the held EF (and BB) bytes are unknown bytes.
         if (s1.mode == M_MARK && (!mark_hit || last_byte)) begin
            if (s1.stage != 2'd0)
               cand[0] = mk(KIND_END, s1.off, '0, s1.lc, FAULT_UNKNOWN);
            if (s1.stage == 2'd2)
               cand[1] = mk(KIND_END, s1.off + OFFSET_BITS'(1), '0, s1.lc, FAULT_UNKNOWN);
            s1.off   = s1.off + OFFSET_BITS'(s1.stage);
            s1.mode  = M_IDLE;
            s1.stage = 2'd0;
         end
         if (!mark_hit && source_byte != 8'd0) begin
            fd      = feed(s1, source_byte);
            s1      = fd.s;
            cand[2] = fd.e0;
            cand[3] = fd.e1;
         end
         if (last_byte || (!mark_hit && source_byte == 8'd0)) begin
            cand[4] = flush_emit(s1);
            cand[5] = mk(KIND_END, s1.off, '0, s1.lc, FAULT_NONE);
            s1.mode = M_IDLE;
            s1.done = 1'b1;
         end
      end
      st_in = accept ? s1 : st_ff;

      grp = '0;
      cnt = '0;
      for (int i = 0; i < 6; i++) begin
         if (cand[i].v && cnt < PUSH_N_BITS'(PUSH_MAX)) begin
            grp.e[cnt[1:0]].r = cand[i].r;
            cnt = cnt + PUSH_N_BITS'(1);
         end
      end
      for (int k = 0; k < PUSH_MAX; k++) begin
         grp.e[k].run_end = (cnt != '0) && (PUSH_N_BITS'(k) == cnt - PUSH_N_BITS'(1));
      end
      grp.n = accept ? cnt : '0;
      push  = grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= clear_state();
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

// ===== rtl/stok_back.sv =====
`timescale 1ns / 1ps
module stok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  stok_pkg::push_type     push,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output stok_pkg::entry_type    head,
   output stok_pkg::q_status_type status
);
   import stok_pkg::*;

   entry_type             q_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wp_ff, wp_in;
   logic [Q_PTR_BITS-1:0] rp_ff, rp_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;
   logic                  pop;

   assign rsp_valid    = count_ff != '0;
   assign pop          = rsp_valid && !rsp_stall;
   assign head         = q_ff[rp_ff];
   assign status.count = count_ff;
   // Room for a full group of tokens from one byte is required to take a byte.
   assign status.stall = count_ff > Q_CNT_BITS'(Q_DEPTH - PUSH_MAX);

   always_comb begin
      wp_in    = wp_ff + Q_PTR_BITS'(push.n);
      rp_in    = rp_ff + Q_PTR_BITS'(pop);
      count_in = count_ff + Q_CNT_BITS'(push.n) - Q_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < PUSH_MAX; k++) begin
         if (PUSH_N_BITS'(k) < push.n) q_ff[wp_ff + Q_PTR_BITS'(k)] <= push.e[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/source_tokenizer.sv =====
`timescale 1ns / 1ps
// Streaming source tokenizer. The block takes one source byte per beat and
// can take a new byte in every cycle: the per-byte scan (mark check, token
// continuation, flush and one-byte tokens) is combinational logic in the front
// part, which writes the zero to four tokens a byte causes into an eight-entry
// result queue in that same cycle. The back part hands out one token beat per
// cycle from the queue head while rsp_stall is low; the input stalls while
// more than four tokens are waiting, so the sustained rate is one byte per cycle
// as long as bytes average no more than one token each; bytes that close one
// token and open another, or the last byte with its end token, give bursts that
// the queue absorbs. run_end marks the last token caused by a byte. Bytes after
// the end of a source give no token until a byte with first_byte set arrives.
// There is no clearing pass after reset.
module source_tokenizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_source_byte,
   input  logic                             req_first_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [5:0]                       rsp_token_kind,
   output logic [stok_pkg::OFFSET_BITS-1:0] rsp_lexeme_start,
   output logic [stok_pkg::LEN_BITS-1:0]    rsp_lexeme_length,
   output logic [stok_pkg::LINE_BITS-1:0]   rsp_line_number,
   output logic [1:0]                       rsp_fault,
   output logic                             rsp_run_end
);
   import stok_pkg::*;

   push_type     push;
   entry_type    head;
   q_status_type q_status;
   logic         accept;

   // A byte beat is taken only when the queue has room for every token it can cause.
   assign req_stall = q_status.stall;
   assign accept    = req_valid && !req_stall;

   stok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .source_byte(req_source_byte),
      .first_byte (req_first_byte),
      .last_byte  (req_last_byte),
      .push       (push)
   );

   stok_back u_back (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .head     (head),
      .status   (q_status)
   );

   // The head entry of the queue drives the result ports directly.
   assign rsp_token_kind    = head.r.kind;
   assign rsp_lexeme_start  = head.r.start;
   assign rsp_lexeme_length = head.r.length;
   assign rsp_line_number   = head.r.line;
   assign rsp_fault         = head.r.fault;
   assign rsp_run_end       = head.run_end;

   // A byte is only taken while the queue can hold a full group of tokens.
   a_room : assert property (@(posedge clock) disable iff (reset)
      accept |-> (q_status.count <= Q_CNT_BITS'(Q_DEPTH - PUSH_MAX)))
      else $error("byte taken without room for its tokens");

   // Tokens are written into the queue only for a byte taken in that cycle.
   a_push : assert property (@(posedge clock) disable iff (reset)
      (push.n != '0) |-> accept)
      else $error("tokens pushed without an accepted byte");

   // The queue count follows pushes and pops exactly.
   a_count : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> q_status.count == $past(q_status.count) + Q_CNT_BITS'($past(push.n))
                        - Q_CNT_BITS'($past(rsp_valid && !rsp_stall)))
      else $error("queue count out of step");

endmodule

// ===== dv/source_tokenizer_tb.sv =====
`timescale 1ns / 1ps
module source_tokenizer_tb;
   import stok_pkg::*;

   // One source byte as offered on the input channel.
   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
   } src_beat_type;

   // One token as it is expected on the result channel.
   typedef struct {
      logic [5:0]  kind;
      logic [23:0] start;
      logic [6:0]  length;
      logic [23:0] line;
      logic [1:0]  fault;
      logic        run_end;
   } token_type;

   // Scanner states of the tokenizer model kept by the testbench.
   typedef enum {
      SC_MARK, SC_IDLE, SC_IDENT, SC_NUM, SC_STR, SC_OP, SC_DOT, SC_SLASH, SC_COMMENT
   } scan_type;

   localparam int          LEX_MAX  = 99;
   localparam logic [23:0] SAT_MAX  = 24'hFFFFFF;
   localparam int          HOLD_LEN = 150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [23:0] rsp_lexeme_start;
   logic [6:0]  rsp_lexeme_length;
   logic [23:0] rsp_line_number;
   logic [1:0]  rsp_fault;
   logic        rsp_run_end;

   source_tokenizer i_dut (.*);

   always #5 clock = ~clock;

   src_beat_type byte_queue[$];   // source bytes waiting to be offered
   token_type    token_queue[$];  // tokens predicted but not yet seen
   token_type    step_tokens[$];  // tokens caused by the byte being scanned
   logic [7:0] text_bytes[$];  // scratch buffer used while building a source

   int send_idle = 0;
   int recv_idle = 0;
   int mismatches = 0;
   int hold_count = 0;
   logic hold_go = 1'b0;
   logic hold_used = 1'b0;

   string keywords[16] = '{"if", "else", "while", "for", "to", "func", "return", "true",
                           "false", "null", "break", "continue", "use", "Num", "Str",
                           "Array"};
   string punctuation = "(){},.;*%[]";
   logic [7:0] mark_bytes[3] = '{8'hEF, 8'hBB, 8'hBF};

   // Scanner state of the model.
   scan_type    scan;
   int          mark_pos;
   logic [7:0]  held[2];
   logic [63:0] kw_window;
   logic [23:0] tok_start;
   int          tok_len;
   logic [23:0] offset;
   logic [23:0] line_no;
   logic [23:0] tok_line;
   logic        src_done;

   function automatic logic [23:0] bump(logic [23:0] v);
      return (v == SAT_MAX) ? v : v + 24'd1;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void clear_scanner();
      scan = SC_MARK;
      mark_pos = 0;
      held[0] = 8'd0;
      held[1] = 8'd0;
      kw_window = 64'd0;
      tok_start = 24'd0;
      tok_len = 0;
      offset = 24'd0;
      line_no = 24'd1;
      tok_line = 24'd1;
      src_done = 1'b0;
   endfunction

   // A byte produces at most four tokens; anything beyond that is dropped.
   function automatic void put_token(logic [5:0] k, logic [23:0] st, int len,
                                     logic [23:0] ln, logic [1:0] f);
      token_type t;
      if (step_tokens.size() >= PUSH_MAX) return;
      t.kind = k;
      t.start = st;
      t.length = len[6:0];
      t.line = ln;
      t.fault = f;
      t.run_end = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic logic [5:0] operator_kind(logic [7:0] c, logic two);
      logic [5:0] base;
      case (c)
         ":": base = KIND_COLON_EQ;
         "=": base = KIND_EQ_EQ;
         "+": base = KIND_PLUS_EQ;
         "-": base = KIND_MINUS_EQ;
         "!": base = KIND_BANG_EQ;
         "<": base = KIND_LESS_EQ;
         default: base = KIND_GREATER_EQ;
      endcase
      return two ? base : base + 6'd1;
   endfunction

   // A keyword matches only when the whole lexeme equals it.
   function automatic logic [5:0] word_kind();
      int n;
      logic same;
      for (int i = 0; i < 16; i++) begin
         n = keywords[i].len();
         same = 1'b1;
         for (int j = 0; j < n; j++)
            if (kw_window[8*j +: 8] != keywords[i][j]) same = 1'b0;
         if (same && n == tok_len) return KIND_KEYWORD0 + 6'(i);
      end
      return KIND_IDENT;
   endfunction

   function automatic void open_token(scan_type m, logic [7:0] c);
      scan = m;
      tok_start = offset;
      tok_line = line_no;
      tok_len = 1;
      kw_window = {56'd0, c};
   endfunction

   function automatic void grow_token(logic [7:0] c);
      if (tok_len < 8) kw_window[8*tok_len +: 8] = c;
      if (tok_len < LEX_MAX) tok_len++;
   endfunction

   function automatic logic lone_pending();
      return held[0] == "&" || held[0] == "|";
   endfunction

   function automatic void close_token();
      case (scan)
         SC_IDENT: put_token(word_kind(), tok_start, tok_len, tok_line, FAULT_NONE);
         SC_NUM: put_token(KIND_NUMBER, tok_start, tok_len, tok_line, FAULT_NONE);
         SC_STR: put_token(KIND_STRING, tok_start, tok_len, tok_line, FAULT_NONE);
         SC_OP: begin
            if (lone_pending()) put_token(KIND_END, tok_start, 0, tok_line, FAULT_LONE);
            else put_token(operator_kind(held[0], 1'b0), tok_start, 1, tok_line, FAULT_NONE);
         end
         SC_DOT: put_token(KIND_DOT, tok_start, 1, tok_line, FAULT_NONE);
         SC_SLASH: put_token(KIND_SLASH, tok_start, 1, tok_line, FAULT_NONE);
         default: ;
      endcase
      scan = SC_IDLE;
   endfunction

   // Classifies a byte that arrives with no token open.
   function automatic void scan_fresh(logic [7:0] c);
      scan = SC_IDLE;
      if (is_space(c)) return;
      if (is_alpha(c)) begin
         open_token(SC_IDENT, c);
         return;
      end
      if (is_digit(c)) begin
         open_token(SC_NUM, c);
         return;
      end
      if (c == ".") begin
         open_token(SC_DOT, c);
         return;
      end
      if (c == "/") begin
         open_token(SC_SLASH, c);
         return;
      end
      if (c == "\"") begin
         // The string lexeme starts after the opening quote.
         open_token(SC_STR, c);
         tok_start = bump(offset);
         tok_len = 0;
         kw_window = 64'd0;
         return;
      end
      if (c == ":" || c == "=" || c == "+" || c == "-" || c == "!" || c == "<" ||
          c == ">" || c == "&" || c == "|") begin
         open_token(SC_OP, c);
         held[0] = c;
         return;
      end
      for (int i = 0; i < 11; i++)
         if (punctuation[i] == c) begin
            put_token(KIND_PUNCT0 + 6'(i), offset, 1, line_no, FAULT_NONE);
            return;
         end
      put_token(KIND_END, offset, 0, line_no, FAULT_UNKNOWN);
   endfunction

   function automatic void scan_byte(logic [7:0] c);
      case (scan)
         SC_IDENT: begin
            if (is_alpha(c) || is_digit(c)) grow_token(c);
            else begin
               close_token();
               scan_fresh(c);
            end
         end
         SC_NUM: begin
            if (is_digit(c) || c == ".") grow_token(c);
            else begin
               close_token();
               scan_fresh(c);
            end
         end
         SC_STR: begin
            if (c == "\"") close_token();
            else grow_token(c);
         end
         SC_OP: begin
            if (lone_pending()) begin
               if (c == held[0]) begin
                  put_token(held[0] == "&" ? KIND_AND_AND : KIND_OR_OR, tok_start, 2,
                            tok_line, FAULT_NONE);
                  scan = SC_IDLE;
               end else begin
                  close_token();
                  scan_fresh(c);
               end
            end else if (c == "=") begin
               put_token(operator_kind(held[0], 1'b1), tok_start, 2, tok_line, FAULT_NONE);
               scan = SC_IDLE;
            end else begin
               close_token();
               scan_fresh(c);
            end
         end
         SC_DOT: begin
            if (is_digit(c)) begin
               scan = SC_NUM;
               grow_token(c);
            end else begin
               close_token();
               scan_fresh(c);
            end
         end
         SC_SLASH: begin
            if (c == "/") scan = SC_COMMENT;
            else begin
               close_token();
               scan_fresh(c);
            end
         end
         SC_COMMENT: begin
            if (c == 8'h0A) scan = SC_IDLE;
         end
         default: scan_fresh(c);
      endcase
      offset = bump(offset);
      if (c == 8'h0A) line_no = bump(line_no);
   endfunction

   // Bytes held for a mark that did not complete are scanned as plain bytes.
   function automatic void replay_mark();
      int n;
      n = mark_pos;
      scan = SC_IDLE;
      mark_pos = 0;
      for (int i = 0; i < n; i++) scan_byte(held[i]);
   endfunction

   function automatic void end_source();
      if (scan == SC_MARK) replay_mark();
      close_token();
      put_token(KIND_END, offset, 0, line_no, FAULT_NONE);
      src_done = 1'b1;
   endfunction

   // Works out the tokens one accepted byte causes and queues them.
   function automatic void tokenize_beat(logic [7:0] c, logic first, logic last);
      step_tokens.delete();
      if (first) clear_scanner();
      if (src_done) return;
      if (scan == SC_MARK && c != 8'd0 && mark_pos < 3 && c == mark_bytes[mark_pos]) begin
         if (mark_pos == 2) begin
            mark_pos = 0;
            scan = SC_IDLE;
            offset = bump(bump(bump(offset)));
         end else begin
            held[mark_pos] = c;
            mark_pos++;
         end
         if (last) end_source();
      end else begin
         if (scan == SC_MARK) replay_mark();
         if (c == 8'd0) end_source();
         else begin
            scan_byte(c);
            if (last) end_source();
         end
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].run_end = 1'b1;
      foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
   endfunction

   // Driver: when the beat has gone or none is up, offers the next or idles at random.
   always @(posedge clock) begin
      src_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            tokenize_beat(req_source_byte, req_first_byte, req_last_byte);
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               b = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_source_byte <= b.data;
               req_first_byte <= b.first;
               req_last_byte <= b.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once, so the result queue fills and the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
      end else if (hold_go && !hold_used) begin
         hold_count <= HOLD_LEN;
         hold_used <= 1'b1;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
      end
   end

   // Monitor: every accepted token beat is checked against the oldest prediction.
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected token beat: kind %0d start %0d", rsp_token_kind,
                           rsp_lexeme_start);
            end else begin
               want = token_queue.pop_front();
               if (rsp_token_kind !== want.kind || rsp_lexeme_start !== want.start ||
                   rsp_lexeme_length !== want.length || rsp_line_number !== want.line ||
                   rsp_fault !== want.fault || rsp_run_end !== want.run_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"token mismatch: expected kind %0d start %0d len %0d line %0d ",
                               "fault %0d end %0b, got kind %0d start %0d len %0d line %0d ",
                               "fault %0d end %0b"},
                              want.kind, want.start, want.length, want.line, want.fault,
                              want.run_end, rsp_token_kind, rsp_lexeme_start,
                              rsp_lexeme_length, rsp_line_number, rsp_fault, rsp_run_end);
               end
            end
         end
         rsp_stall <= (hold_count != 0) || ($urandom_range(0, 99) < recv_idle);
      end
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   // Moves the scratch buffer into the byte queue as one source.
   task automatic queue_source(logic last_on_final);
      src_beat_type b;
      foreach (text_bytes[i]) begin
         b.data = text_bytes[i];
         b.first = (i == 0);
         b.last = last_on_final && (i == text_bytes.size() - 1);
         byte_queue.push_back(b);
      end
      text_bytes.delete();
   endtask

   task automatic add_word(int len);
      int r;
      r = $urandom_range(0, 2);
      text_bytes.push_back(r == 0 ? 8'($urandom_range("a", "z")) :
                           r == 1 ? 8'($urandom_range("A", "Z")) : 8'("_"));
      for (int i = 1; i < len; i++) begin
         r = $urandom_range(0, 3);
         text_bytes.push_back(r == 0 ? 8'($urandom_range("0", "9")) :
                              r == 1 ? 8'($urandom_range("A", "Z")) :
                              8'($urandom_range("a", "z")));
      end
   endtask

   // Builds a random source of well-formed tokens with some noise mixed in.
   task automatic build_source(output int nbytes);
      string ops[13] = '{":", "=", "+", "-", "!", "<", ">", ":=", "==", "+=", "-=", "!=", "<="};
      int ntok;
      int ending;
      text_bytes.delete();
      case ($urandom_range(0, 7))
         0, 1: add_text("\xEF\xBB\xBF");
         2: add_text("\xEF");
         3: add_text("\xEF\xBB");
         default: ;
      endcase
      ntok = $urandom_range(2, 10);
      for (int t = 0; t < ntok; t++) begin
         case ($urandom_range(0, 12))
            0: add_text(keywords[$urandom_range(0, 15)]);
            1: add_word($urandom_range(0, 15) == 0 ? $urandom_range(100, 104)
                                                   : $urandom_range(1, 11));
            2: begin
               if ($urandom_range(0, 3) == 0) text_bytes.push_back(".");
               repeat ($urandom_range(1, 5))
                  text_bytes.push_back($urandom_range(0, 4) == 0 ? 8'(".")
                                                               : 8'($urandom_range("0", "9")));
            end
            3: begin
               text_bytes.push_back("\"");
               repeat ($urandom_range(0, 6)) text_bytes.push_back(8'($urandom_range(32, 126)));
               if ($urandom_range(0, 5) != 0) text_bytes.push_back("\"");
            end
            4: add_text(ops[$urandom_range(0, 12)]);
            5: add_text($urandom_range(0, 1) ? ">=" : ">");
            6: add_text($urandom_range(0, 1) ? "&&" : ($urandom_range(0, 1) ? "||" : "&"));
            7: add_text($urandom_range(0, 1) ? "|" : "/");
            8: begin
               add_text("//");
               repeat ($urandom_range(0, 4)) text_bytes.push_back(8'($urandom_range(32, 255)));
               text_bytes.push_back(8'h0A);
            end
            9: text_bytes.push_back(punctuation[$urandom_range(0, 10)]);
            10: text_bytes.push_back($urandom_range(0, 1) ? 8'h0A : 8'($urandom_range(9, 13)));
            11: text_bytes.push_back(8'($urandom_range(1, 255)));
            default: text_bytes.push_back(" ");
         endcase
         if ($urandom_range(0, 1)) text_bytes.push_back(" ");
      end
      nbytes = text_bytes.size();
      // Sources end on the last flag, on a zero byte (sometimes with ignored bytes
      // after it), or not at all when the next source simply starts over.
      ending = $urandom_range(0, 3);
      if (ending == 1 || ending == 2) text_bytes.push_back(8'd0);
      if (ending == 2) repeat (2) text_bytes.push_back(8'($urandom_range(0, 255)));
      queue_source(ending == 0);
   endtask

   task automatic run_random(int budget);
      int n;
      while (budget > 0) begin
         build_source(n);
         budget -= n;
      end
   endtask

   task automatic drain();
      while (byte_queue.size() != 0 || req_valid || token_queue.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clear_scanner();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle = 33;
      recv_idle = 82;
      // Full mark, keyword, identifier, two-byte operator, dot number, string and a
      // lone bar closed by a zero byte; the byte after the end is ignored.
      add_text("\xEF\xBB\xBFif a1:=.5\"s\"|");
      text_bytes.push_back(8'd0);
      text_bytes.push_back("z");
      queue_source(1'b0);
      // Broken mark, newline, comment, a high byte and a lone ampersand at the end.
      add_text("\xEFa\n//c\n\xFF&");
      queue_source(1'b1);
      // A new source that starts in the middle of a token drops it silently.
      add_text("ab");
      queue_source(1'b0);
      add_text("\"x");
      queue_source(1'b1);
      run_random(30);
      drain();

      send_idle = 82;
      recv_idle = 33;
      run_random(30);
      drain();

      send_idle = 0;
      recv_idle = 0;
      hold_go <= 1'b1;
      run_random(30);
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && token_queue.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
